// File: rtl/midpoint_circle_octant_raster_defines.svh
// Assertion macros shared by the circle rasterizer RTL.
`ifndef MIDPOINT_CIRCLE_OCTANT_RASTER_DEFINES_SVH
`define MIDPOINT_CIRCLE_OCTANT_RASTER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define MCOR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define MCOR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MCOR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MCOR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/mcor_pkg.sv
package mcor_pkg;

	// Field widths
	localparam int IN_CRD_W = 12;
	localparam int RAD_W    = 11;
	localparam int STEP_W   = 12;
	localparam int DEC_W    = 16;
	localparam int PIX_W    = 14;
	localparam int COLOR_W  = 4;

	localparam logic [COLOR_W-1:0] COLOR_RESET = 4'd14;

	// Command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// Decision constants
	localparam logic [DEC_W-1:0] DEC_INIT      = 16'd3;
	localparam logic [DEC_W-1:0] DEC_INC_HOLD  = 16'd6;
	localparam logic [DEC_W-1:0] DEC_INC_DROP  = 16'd10;

	// Octant index within a group of eight pixels
	typedef logic [2:0] oct_t;
	localparam oct_t OCT_FIRST = 3'd0;
	localparam oct_t OCT_LAST  = 3'd7;

	// One point of the octant plus the center, ready for mirroring
	typedef struct packed {
		logic [PIX_W-1:0]  cx;
		logic [PIX_W-1:0]  cy;
		logic [STEP_W-1:0] x;
		logic [STEP_W-1:0] y;
		logic              done;
	} grp_t;

endpackage

// File: rtl/mcor_stream_if.sv
interface mcor_item_if import mcor_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                cmd;
	logic [IN_CRD_W-1:0] center_x;
	logic [IN_CRD_W-1:0] center_y;
	logic [RAD_W-1:0]    radius;

	modport source (output valid, cmd, center_x, center_y, radius, input ready);
	modport sink   (input valid, cmd, center_x, center_y, radius, output ready);
endinterface

interface mcor_pixel_if import mcor_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [PIX_W-1:0] pixel_x;
	logic signed [PIX_W-1:0] pixel_y;
	logic [COLOR_W-1:0]      pixel_color;
	logic                    last_of_step;
	logic                    circle_done;

	modport source (output valid, pixel_x, pixel_y, pixel_color, last_of_step, circle_done,
		input ready);
	modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_of_step, circle_done,
		output ready);
endinterface

// File: rtl/mcor_octant_emit.sv
`include "midpoint_circle_octant_raster_defines.svh"

module mcor_octant_emit import mcor_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               grp_load,
	input  grp_t               grp,
	output logic               grp_free,
	input  logic [COLOR_W-1:0] draw_color,
	mcor_pixel_if.source       pixel
);

	grp_t             grp_q;
	logic             grp_valid_q;
	oct_t             oct_q;
	logic             adv;
	logic [PIX_W-1:0] ex, ey;
	logic [PIX_W-1:0] px, py;

	logic                    out_valid_q;
	logic signed [PIX_W-1:0] out_x_q, out_y_q;
	logic [COLOR_W-1:0]      out_color_q;
	logic                    out_last_q, out_done_q;

	// Move one pixel into the output register when it is empty or draining
	assign adv      = grp_valid_q && (!out_valid_q || pixel.ready);
	assign grp_free = !grp_valid_q || (adv && oct_q == OCT_LAST);

	// Sign-extend the octant point to pixel width
	assign ex = {{(PIX_W-STEP_W){grp_q.x[STEP_W-1]}}, grp_q.x};
	assign ey = {{(PIX_W-STEP_W){grp_q.y[STEP_W-1]}}, grp_q.y};

	// Mirror the point into the current octant
	always_comb begin
		unique case (oct_q)
			3'd0: begin px = grp_q.cx + ey; py = grp_q.cy + ex; end
			3'd1: begin px = grp_q.cx + ex; py = grp_q.cy + ey; end
			3'd2: begin px = grp_q.cx - ex; py = grp_q.cy + ey; end
			3'd3: begin px = grp_q.cx - ey; py = grp_q.cy + ex; end
			3'd4: begin px = grp_q.cx - ey; py = grp_q.cy - ex; end
			3'd5: begin px = grp_q.cx - ex; py = grp_q.cy - ey; end
			3'd6: begin px = grp_q.cx + ex; py = grp_q.cy - ey; end
			3'd7: begin px = grp_q.cx + ey; py = grp_q.cy - ex; end
			default: begin px = '0; py = '0; end
		endcase
	end

	// Hold the group and walk its eight octants
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_q <= 1'b0;
			oct_q       <= OCT_FIRST;
		end else if (grp_load) begin
			grp_valid_q <= 1'b1;
			oct_q       <= OCT_FIRST;
		end else if (adv) begin
			oct_q <= oct_q + 3'd1;
			if (oct_q == OCT_LAST)
				grp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_load)
			grp_q <= grp;
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (pixel.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			out_x_q     <= px;
			out_y_q     <= py;
			out_color_q <= draw_color;
			out_last_q  <= (oct_q == OCT_LAST);
			out_done_q  <= grp_q.done;
		end
	end

	assign pixel.valid        = out_valid_q;
	assign pixel.pixel_x      = out_x_q;
	assign pixel.pixel_y      = out_y_q;
	assign pixel.pixel_color  = out_color_q;
	assign pixel.last_of_step = out_last_q;
	assign pixel.circle_done  = out_done_q;

	`MCOR_ASSERT_IMPLY(a_busy_not_free, clk, arst_n, grp_valid_q && (oct_q != OCT_LAST), !grp_free)
	`MCOR_ASSERT_IMPLY(a_load_when_free, clk, arst_n, grp_load, grp_free)
	`MCOR_ASSERT_NEXT(a_load_starts, clk, arst_n, grp_load, grp_valid_q && (oct_q == OCT_FIRST))

endmodule

// File: rtl/midpoint_circle_octant_raster.sv
// Channel  | Dir | Transfer                  | Payload
// item     | in  | item.valid & item.ready   | cmd, center_x, center_y, radius
// pixel    | out | pixel.valid & pixel.ready | pixel_x, pixel_y, pixel_color, last_of_step,
//          |     |                           | circle_done
// cfg      | in  | cfg_we                    | cfg_wdata (draw color)
//
// An item is decoded in the cycle of its transfer; its eight pixels enter the output register
// one per edge after it while the pixel channel does not stall; the group register sits between
// the item and the output register. The octant walker holds one group; the next item transfers
// at the edge that loads the eighth pixel into the output register. A step while idle produces no pixels.
// Reset clears the circle state and sets the draw color to 14; no clearing pass.
// A stalled pixel channel holds the output register and, after one group, the item channel.

`include "midpoint_circle_octant_raster_defines.svh"

module midpoint_circle_octant_raster import mcor_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	mcor_item_if.sink          item,
	mcor_pixel_if.source       pixel,
	input  logic               cfg_we,
	input  logic [COLOR_W-1:0] cfg_wdata
);

	logic [STEP_W-1:0]     cur_x_q, cur_y_q;
	logic [DEC_W-1:0]      dec_q;
	logic [COORD_BITS-1:0] ccol_q, crow_q;
	logic                  active_q;
	logic [COLOR_W-1:0]    color_q;

	logic                  accept, is_start, grp_load, grp_free;
	logic [STEP_W-1:0]     nx, ny;
	logic [DEC_W-1:0]      nd, dx4;
	logic [COORD_BITS-1:0] ncol, nrow;
	logic                  ndone;
	grp_t                  grp;

	assign item.ready = grp_free;
	assign accept     = item.valid && item.ready;
	assign is_start   = (item.cmd == CMD_START);
	assign grp_load   = accept && (is_start || active_q);

	// Next point and decision of one start or step
	always_comb begin
		nx   = cur_x_q;
		ny   = cur_y_q;
		nd   = dec_q;
		dx4  = '0;
		ncol = ccol_q;
		nrow = crow_q;
		if (is_start) begin
			ncol = COORD_BITS'(item.center_x);
			nrow = COORD_BITS'(item.center_y);
			nx   = '0;
			ny   = STEP_W'(item.radius);
			nd   = DEC_INIT - {{(DEC_W-RAD_W-1){1'b0}}, item.radius, 1'b0};
		end else begin
			nx = cur_x_q + STEP_W'(1);
			if (dec_q[DEC_W-1]) begin
				// Decision negative: hold y
				dx4 = {{(DEC_W-STEP_W-2){nx[STEP_W-1]}}, nx, 2'b00};
				nd  = dec_q + dx4 + DEC_INC_HOLD;
			end else begin
				// Decision non-negative: drop y
				ny  = cur_y_q - STEP_W'(1);
				dx4 = ({{(DEC_W-STEP_W){nx[STEP_W-1]}}, nx}
					- {{(DEC_W-STEP_W){ny[STEP_W-1]}}, ny}) << 2;
				nd  = dec_q + dx4 + DEC_INC_DROP;
			end
		end
	end

	assign ndone = !is_start && ($signed(ny) < $signed(nx));

	assign grp.cx   = PIX_W'(ncol);
	assign grp.cy   = PIX_W'(nrow);
	assign grp.x    = nx;
	assign grp.y    = ny;
	assign grp.done = ndone;

	// Circle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			dec_q    <= '0;
			ccol_q   <= '0;
			crow_q   <= '0;
			active_q <= 1'b0;
		end else if (grp_load) begin
			cur_x_q  <= nx;
			cur_y_q  <= ny;
			dec_q    <= nd;
			ccol_q   <= ncol;
			crow_q   <= nrow;
			active_q <= !ndone;
		end
	end

	// Draw color register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= COLOR_RESET;
		end else if (cfg_we) begin
			color_q <= cfg_wdata;
		end
	end

	mcor_octant_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.grp_load   (grp_load),
		.grp        (grp),
		.grp_free   (grp_free),
		.draw_color (color_q),
		.pixel      (pixel)
	);

	`MCOR_ASSERT_NEXT(a_start_active, clk, arst_n, accept && is_start, active_q)
	`MCOR_ASSERT_NEXT(a_idle_step_holds, clk, arst_n, accept && !is_start && !active_q, $stable(cur_x_q) && $stable(dec_q) && !active_q)
	`MCOR_ASSERT_NEXT(a_done_idles, clk, arst_n, grp_load && ndone, !active_q)

endmodule

// File: bench/testbench.sv
module testbench;
	import mcor_pkg::*;

	// One emitted pixel as seen on the result channel
	typedef struct packed {
		logic [PIX_W-1:0]   px;
		logic [PIX_W-1:0]   py;
		logic [COLOR_W-1:0] color;
		logic               last;
		logic               done;
	} pixel_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [COLOR_W-1:0] cfg_wdata = '0;

	int src_idle_pct = 33;
	int snk_idle_pct = 75;
	int errors = 0;

	// Pixels still owed by the block, oldest first
	pixel_t pixels_due[$];

	// Walker state mirrored from the block
	logic signed [STEP_W-1:0] walk_x = '0;
	logic signed [STEP_W-1:0] walk_y = '0;
	logic signed [DEC_W-1:0]  walk_dec = '0;
	logic [IN_CRD_W-1:0]      orig_col = '0;
	logic [IN_CRD_W-1:0]      orig_row = '0;
	bit                       drawing = 1'b0;
	logic [COLOR_W-1:0]       color_now = COLOR_RESET;

	mcor_item_if  item_bus ();
	mcor_pixel_if pixel_bus ();

	midpoint_circle_octant_raster u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_bus),
		.pixel    (pixel_bus),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// Mirror the current point into its eight octant pixels
	function automatic void push_octants(bit done);
		int     cx;
		int     cy;
		int     x;
		int     y;
		int     gx[8];
		int     gy[8];
		pixel_t p;
		cx = int'(orig_col);
		cy = int'(orig_row);
		x  = int'(walk_x);
		y  = int'(walk_y);
		gx = '{cx + y, cx + x, cx - x, cx - y, cx - y, cx - x, cx + x, cx + y};
		gy = '{cy + x, cy + y, cy + y, cy + x, cy - x, cy - y, cy - y, cy - x};
		for (int k = 0; k < 8; k++) begin
			p.px    = gx[k][PIX_W-1:0];
			p.py    = gy[k][PIX_W-1:0];
			p.color = color_now;
			p.last  = (oct_t'(k) == OCT_LAST);
			p.done  = done;
			pixels_due.push_back(p);
		end
	endfunction

	// Apply one accepted item to the walker and queue the pixels it owes
	function automatic void advance_circle(logic cmd, logic [IN_CRD_W-1:0] cx,
			logic [IN_CRD_W-1:0] cy, logic [RAD_W-1:0] r);
		bit done;
		if (cmd == CMD_START) begin
			orig_col = cx;
			orig_row = cy;
			walk_x   = '0;
			walk_y   = STEP_W'(r);
			walk_dec = DEC_W'(int'(DEC_INIT) - 2 * int'(r));
			drawing  = 1'b1;
			push_octants(1'b0);
		end else if (drawing) begin
			walk_x = walk_x + 1'b1;
			if (walk_dec < 0) begin
				walk_dec = DEC_W'(int'(walk_dec) + 4 * int'(walk_x) + int'(DEC_INC_HOLD));
			end else begin
				walk_y   = walk_y - 1'b1;
				walk_dec = DEC_W'(int'(walk_dec) + 4 * (int'(walk_x) - int'(walk_y))
					+ int'(DEC_INC_DROP));
			end
			done = (walk_y < walk_x);
			push_octants(done);
			if (done)
				drawing = 1'b0;
		end
	endfunction

	// Offer one item, idling first at random, and return at its transfer
	task automatic send_item(logic cmd, logic [IN_CRD_W-1:0] cx, logic [IN_CRD_W-1:0] cy,
			logic [RAD_W-1:0] r);
		while ($urandom_range(99) < src_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid    <= 1'b1;
		item_bus.cmd      <= cmd;
		item_bus.center_x <= cx;
		item_bus.center_y <= cy;
		item_bus.radius   <= r;
		@(posedge clk);
		while (!item_bus.ready)
			@(posedge clk);
		advance_circle(cmd, cx, cy, r);
	endtask

	task automatic send_step();
		send_item(CMD_STEP, IN_CRD_W'($urandom), IN_CRD_W'($urandom), RAD_W'($urandom));
	endtask

	// Step until the running circle finishes
	task automatic draw_rest();
		while (drawing)
			send_step();
	endtask

	// Drop valid, drain all owed pixels, then let an ignored step settle
	task automatic wait_idle();
		item_bus.valid <= 1'b0;
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_color(logic [COLOR_W-1:0] c);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we    <= 1'b0;
		color_now = c;
	endtask

	// Step while idle, then a zero radius circle at the origin and a step past its end
	task automatic test_idle_and_zero();
		send_step();
		send_item(CMD_START, '0, '0, '0);
		draw_rest();
		send_step();
		wait_idle();
	endtask

	// Largest radius at both corners, restart while active, radius one
	task automatic test_extremes();
		send_item(CMD_START, '1, '1, '1);
		repeat (3) send_step();
		send_item(CMD_START, '0, '0, '1);
		repeat (3) send_step();
		send_item(CMD_START, '1, '0, RAD_W'(1));
		draw_rest();
		send_item(CMD_START, IN_CRD_W'(2048), IN_CRD_W'(2047), RAD_W'(1024));
		repeat (2) send_step();
		wait_idle();
	endtask

	// Both color extremes on a short circle each
	task automatic test_draw_color();
		set_color('1);
		send_item(CMD_START, IN_CRD_W'(100), IN_CRD_W'(200), RAD_W'(5));
		draw_rest();
		wait_idle();
		set_color('0);
		send_item(CMD_START, IN_CRD_W'(7), IN_CRD_W'(4000), RAD_W'(3));
		draw_rest();
		wait_idle();
	endtask

	// Mostly complete small circles; some large ones and some abandoned early
	task automatic test_random_circles(int n_items, int src_pct, int snk_pct);
		int               sent;
		int               steps_left;
		bit               big;
		logic [RAD_W-1:0] r;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		set_color(COLOR_W'($urandom));
		sent = 0;
		while (sent < n_items) begin
			big = ($urandom_range(7) == 0);
			r   = big ? RAD_W'($urandom) : RAD_W'($urandom_range(24));
			send_item(CMD_START, IN_CRD_W'($urandom), IN_CRD_W'($urandom), r);
			sent++;
			steps_left = (big || $urandom_range(5) == 0) ? $urandom_range(6) : 4096;
			while (drawing && steps_left > 0 && sent < n_items) begin
				send_step();
				sent++;
				steps_left--;
			end
			// Occasional step after the finish, which must produce nothing
			if (!drawing && $urandom_range(9) == 0)
				send_step();
		end
		wait_idle();
	endtask

	// Receiver stalls at random
	always @(posedge clk)
		pixel_bus.ready <= ($urandom_range(99) >= snk_idle_pct);

	// Check each pixel transfer against the oldest owed pixel
	always @(posedge clk) begin
		pixel_t seen;
		pixel_t want;
		if (arst_n && pixel_bus.valid && pixel_bus.ready) begin
			seen = '{pixel_bus.pixel_x, pixel_bus.pixel_y, pixel_bus.pixel_color,
				pixel_bus.last_of_step, pixel_bus.circle_done};
			if (pixels_due.size() == 0) begin
				errors++;
				$display("%0t: expected no pixel, got x=%0d y=%0d color=%0d last=%0b done=%0b",
					$time, $signed(seen.px), $signed(seen.py), seen.color, seen.last,
					seen.done);
			end else begin
				want = pixels_due.pop_front();
				if (seen.px !== want.px || seen.py !== want.py || seen.color !== want.color
						|| seen.last !== want.last || seen.done !== want.done) begin
					errors++;
					$display("%0t: expected x=%0d y=%0d color=%0d last=%0b done=%0b, got x=%0d y=%0d color=%0d last=%0b done=%0b",
						$time, $signed(want.px), $signed(want.py), want.color, want.last,
						want.done, $signed(seen.px), $signed(seen.py), seen.color,
						seen.last, seen.done);
				end
			end
		end
	end

	initial begin
		item_bus.valid    = 1'b0;
		item_bus.cmd      = CMD_START;
		item_bus.center_x = '0;
		item_bus.center_y = '0;
		item_bus.radius   = '0;
		pixel_bus.ready   = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_idle_and_zero();
		test_extremes();
		test_draw_color();
		test_random_circles(45, 33, 75);
		test_random_circles(45, 75, 33);
		test_random_circles(45, 0, 0);
		wait_idle();
		if (errors == 0 && pixels_due.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

	// Hang guard
	initial begin
		#2000000;
		$display("testbench: errors");
		$finish;
	end

endmodule
